>>> hdl/spwc_pkg.sv
// spwc_pkg: shared constants, codes and controller/datapath link types
// for the single page write-back cache; used by every file of the block but spwc_ram
package spwc_pkg;

   localparam int PAGE_WORDS_DEF = 512;
   localparam int ADDR_BITS_DEF  = 18;
   localparam int WORD_BITS_DEF  = 36;

   localparam int OP_BITS   = 3;
   localparam int KIND_BITS = 3;

   localparam logic [OP_BITS-1:0] OP_READ  = 3'd0;
   localparam logic [OP_BITS-1:0] OP_WRITE = 3'd1;
   localparam logic [OP_BITS-1:0] OP_TICK  = 3'd2;
   localparam logic [OP_BITS-1:0] OP_PULL  = 3'd3;
   localparam logic [OP_BITS-1:0] OP_FILL  = 3'd4;

   localparam logic [KIND_BITS-1:0] KIND_WRITE_ACK = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_READ_DATA = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_WB_NEEDED = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_WB_WORD   = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_FETCH     = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_ERROR     = 3'd5;

   localparam logic [1:0] PEND_READ  = 2'd0;
   localparam logic [1:0] PEND_WRITE = 2'd1;
   localparam logic [1:0] PEND_FLUSH = 2'd2;

   localparam logic [1:0] ASEL_REQ  = 2'd0;
   localparam logic [1:0] ASEL_CNT  = 2'd1;
   localparam logic [1:0] ASEL_PEND = 2'd2;

   localparam logic [1:0] PSEL_ZERO = 2'd0;
   localparam logic [1:0] PSEL_TAG  = 2'd1;
   localparam logic [1:0] PSEL_REQ  = 2'd2;
   localparam logic [1:0] PSEL_PEND = 2'd3;

   typedef struct packed {
      logic                 mem_we;
      logic [1:0]           waddr_sel;
      logic                 wdata_pend;
      logic [1:0]           raddr_sel;
      logic                 load_pending;
      logic                 cnt_clr;
      logic                 cnt_inc;
      logic                 load_tag;
      logic                 out_load;
      logic [KIND_BITS-1:0] out_kind;
      logic [1:0]           page_sel;
      logic                 index_cnt;
      logic                 data_rd;
      logic                 out_last;
   } cmd_type;

   typedef struct packed {
      logic tag_match;
      logic counter_last;
      logic out_free;
   } status_type;

endpackage

>>> hdl/spwc_if.sv
// spwc_req_if / spwc_rsp_if: valid-ready channels of the cache
// depends on spwc_pkg for field widths
interface spwc_req_if #(
   parameter int ADDR_BITS = spwc_pkg::ADDR_BITS_DEF,
   parameter int WORD_BITS = spwc_pkg::WORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic [spwc_pkg::OP_BITS-1:0] op;
   logic [ADDR_BITS-1:0]         address;
   logic [WORD_BITS-1:0]         data;

   modport source (output valid, output op, output address, output data, input ready);
   modport sink   (input valid, input op, input address, input data, output ready);
endinterface

interface spwc_rsp_if #(
   parameter int PAGE_BITS = spwc_pkg::ADDR_BITS_DEF - $clog2(spwc_pkg::PAGE_WORDS_DEF),
   parameter int IDX_BITS  = $clog2(spwc_pkg::PAGE_WORDS_DEF),
   parameter int WORD_BITS = spwc_pkg::WORD_BITS_DEF
);
   logic                           valid;
   logic                           ready;
   logic [spwc_pkg::KIND_BITS-1:0] kind;
   logic [PAGE_BITS-1:0]           page;
   logic [IDX_BITS-1:0]            index;
   logic [WORD_BITS-1:0]           data_res;
   logic                           last;

   modport source (output valid, output kind, output page, output index, output data_res,
                   output last, input ready);
   modport sink   (input valid, input kind, input page, input index, input data_res,
                   input last, output ready);
endinterface

>>> hdl/spwc_ram.sv
// spwc_ram: generic single write port ram with registered read
// no dependencies
module spwc_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hdl/spwc_ctrl.sv
// spwc_ctrl: controller state machine, holds phase, valid, dirty and pending kind
// depends on spwc_pkg; drives the datapath by cmd_type, reads status_type
module spwc_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [spwc_pkg::OP_BITS-1:0] req_op,
   output logic                         req_ready,
   input  spwc_pkg::status_type         status,
   output spwc_pkg::cmd_type            cmd
);
   localparam logic [2:0] S_ACCEPT   = 3'd0;
   localparam logic [2:0] S_RESP     = 3'd1;
   localparam logic [2:0] S_SECOND   = 3'd2;
   localparam logic [2:0] S_SERVE_RD = 3'd3;
   localparam logic [2:0] S_SERVE_WR = 3'd4;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_DRAIN = 2'd1;
   localparam logic [1:0] PH_FILL  = 2'd2;

   logic [2:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       valid_ff, valid_in;
   logic       dirty_ff, dirty_in;
   logic [1:0] pend_ff, pend_in;
   logic       resp_wb_ff, resp_wb_in;
   logic       accept;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      phase_in   = phase_ff;
      valid_in   = valid_ff;
      dirty_in   = dirty_ff;
      pend_in    = pend_ff;
      resp_wb_in = resp_wb_ff;
      req_ready  = (state_ff == S_ACCEPT) && status.out_free;
      accept     = req_valid && req_ready;
      case (state_ff)
         S_ACCEPT: begin
            if (accept) begin
               cmd.out_last = 1'b1;
               case (req_op)
                  spwc_pkg::OP_READ, spwc_pkg::OP_WRITE: begin
                     if (phase_ff != PH_IDLE) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = spwc_pkg::KIND_ERROR;
                     end else if (valid_ff && status.tag_match) begin
                        if (req_op == spwc_pkg::OP_WRITE) begin
                           cmd.mem_we    = 1'b1;
                           cmd.waddr_sel = spwc_pkg::ASEL_REQ;
                           cmd.out_load  = 1'b1;
                           cmd.out_kind  = spwc_pkg::KIND_WRITE_ACK;
                           dirty_in      = 1'b1;
                        end else begin
                           cmd.raddr_sel = spwc_pkg::ASEL_REQ;
                           resp_wb_in    = 1'b0;
                           state_in      = S_RESP;
                        end
                     end else begin
                        cmd.load_pending = 1'b1;
                        cmd.cnt_clr      = 1'b1;
                        cmd.out_load     = 1'b1;
                        pend_in          = (req_op == spwc_pkg::OP_WRITE) ?
                                           spwc_pkg::PEND_WRITE : spwc_pkg::PEND_READ;
                        if (valid_ff && dirty_ff) begin
                           phase_in     = PH_DRAIN;
                           cmd.out_kind = spwc_pkg::KIND_WB_NEEDED;
                           cmd.page_sel = spwc_pkg::PSEL_TAG;
                        end else begin
                           valid_in     = 1'b0;
                           dirty_in     = 1'b0;
                           phase_in     = PH_FILL;
                           cmd.out_kind = spwc_pkg::KIND_FETCH;
                           cmd.page_sel = spwc_pkg::PSEL_REQ;
                        end
                     end
                  end
                  spwc_pkg::OP_TICK: begin
                     if (phase_ff != PH_IDLE) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = spwc_pkg::KIND_ERROR;
                     end else if (valid_ff && dirty_ff) begin
                        pend_in      = spwc_pkg::PEND_FLUSH;
                        cmd.cnt_clr  = 1'b1;
                        phase_in     = PH_DRAIN;
                        cmd.out_load = 1'b1;
                        cmd.out_kind = spwc_pkg::KIND_WB_NEEDED;
                        cmd.page_sel = spwc_pkg::PSEL_TAG;
                     end else begin
                        valid_in = 1'b0;
                        dirty_in = 1'b0;
                     end
                  end
                  spwc_pkg::OP_PULL: begin
                     if (phase_ff != PH_DRAIN) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = spwc_pkg::KIND_ERROR;
                     end else begin
                        cmd.raddr_sel = spwc_pkg::ASEL_CNT;
                        resp_wb_in    = 1'b1;
                        state_in      = S_RESP;
                     end
                  end
                  spwc_pkg::OP_FILL: begin
                     if (phase_ff != PH_FILL) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = spwc_pkg::KIND_ERROR;
                     end else begin
                        cmd.mem_we    = 1'b1;
                        cmd.waddr_sel = spwc_pkg::ASEL_CNT;
                        if (!status.counter_last) begin
                           cmd.cnt_inc = 1'b1;
                        end else begin
                           cmd.cnt_clr  = 1'b1;
                           cmd.load_tag = 1'b1;
                           phase_in     = PH_IDLE;
                           valid_in     = 1'b1;
                           dirty_in     = 1'b0;
                           state_in     = (pend_ff == spwc_pkg::PEND_WRITE) ?
                                          S_SERVE_WR : S_SERVE_RD;
                        end
                     end
                  end
                  default: begin
                     cmd.out_load = 1'b1;
                     cmd.out_kind = spwc_pkg::KIND_ERROR;
                  end
               endcase
            end
         end
         S_RESP: begin
            cmd.out_load = 1'b1;
            cmd.data_rd  = 1'b1;
            cmd.out_last = 1'b1;
            state_in     = S_ACCEPT;
            if (resp_wb_ff) begin
               cmd.out_kind  = spwc_pkg::KIND_WB_WORD;
               cmd.index_cnt = 1'b1;
               if (status.counter_last) begin
                  cmd.cnt_clr = 1'b1;
                  valid_in    = 1'b0;
                  dirty_in    = 1'b0;
                  if (pend_ff == spwc_pkg::PEND_FLUSH) begin
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in     = PH_FILL;
                     cmd.out_last = 1'b0;
                     state_in     = S_SECOND;
                  end
               end else begin
                  cmd.cnt_inc = 1'b1;
               end
            end else begin
               cmd.out_kind = spwc_pkg::KIND_READ_DATA;
            end
         end
         S_SECOND: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = spwc_pkg::KIND_FETCH;
               cmd.page_sel = spwc_pkg::PSEL_PEND;
               cmd.out_last = 1'b1;
               state_in     = S_ACCEPT;
            end
         end
         S_SERVE_RD: begin
            cmd.raddr_sel = spwc_pkg::ASEL_PEND;
            resp_wb_in    = 1'b0;
            state_in      = S_RESP;
         end
         S_SERVE_WR: begin
            cmd.mem_we     = 1'b1;
            cmd.waddr_sel  = spwc_pkg::ASEL_PEND;
            cmd.wdata_pend = 1'b1;
            cmd.out_load   = 1'b1;
            cmd.out_kind   = spwc_pkg::KIND_WRITE_ACK;
            cmd.out_last   = 1'b1;
            dirty_in       = 1'b1;
            state_in       = S_ACCEPT;
         end
         default: begin
            state_in = S_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_ACCEPT;
         phase_ff   <= PH_IDLE;
         valid_ff   <= 1'b0;
         dirty_ff   <= 1'b0;
         pend_ff    <= spwc_pkg::PEND_READ;
         resp_wb_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         valid_ff   <= valid_in;
         dirty_ff   <= dirty_in;
         pend_ff    <= pend_in;
         resp_wb_ff <= resp_wb_in;
      end
   end
endmodule

>>> hdl/spwc_datapath.sv
// spwc_datapath: page store, tag, word counter, saved request and result register
// depends on spwc_pkg and spwc_ram; steered by cmd_type from spwc_ctrl
module spwc_datapath #(
   parameter int PAGE_WORDS = spwc_pkg::PAGE_WORDS_DEF,
   parameter int ADDR_BITS  = spwc_pkg::ADDR_BITS_DEF,
   parameter int WORD_BITS  = spwc_pkg::WORD_BITS_DEF,
   localparam int IDX_BITS  = $clog2(PAGE_WORDS),
   localparam int PAGE_BITS = ADDR_BITS - IDX_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [ADDR_BITS-1:0]           req_address,
   input  logic [WORD_BITS-1:0]           req_data,
   input  spwc_pkg::cmd_type              cmd,
   output spwc_pkg::status_type           status,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [spwc_pkg::KIND_BITS-1:0] rsp_kind,
   output logic [PAGE_BITS-1:0]           rsp_page,
   output logic [IDX_BITS-1:0]            rsp_index,
   output logic [WORD_BITS-1:0]           rsp_data_res,
   output logic                           rsp_last
);
   logic [PAGE_BITS-1:0]           tag_ff, tag_in;
   logic [IDX_BITS-1:0]            cnt_ff, cnt_in;
   logic [ADDR_BITS-1:0]           pend_addr_ff;
   logic [WORD_BITS-1:0]           pend_data_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [spwc_pkg::KIND_BITS-1:0] rsp_kind_ff;
   logic [PAGE_BITS-1:0]           rsp_page_ff, page_mux;
   logic [IDX_BITS-1:0]            rsp_index_ff;
   logic [WORD_BITS-1:0]           rsp_data_ff;
   logic                           rsp_last_ff;
   logic [IDX_BITS-1:0]            waddr, raddr;
   logic [WORD_BITS-1:0]           wdata, rdata;
   logic [IDX_BITS-1:0]            req_idx, pend_idx;
   logic [PAGE_BITS-1:0]           req_page, pend_page;

   assign req_idx   = req_address[IDX_BITS-1:0];
   assign req_page  = req_address[ADDR_BITS-1:IDX_BITS];
   assign pend_idx  = pend_addr_ff[IDX_BITS-1:0];
   assign pend_page = pend_addr_ff[ADDR_BITS-1:IDX_BITS];

   always_comb begin
      case (cmd.waddr_sel)
         spwc_pkg::ASEL_REQ:  waddr = req_idx;
         spwc_pkg::ASEL_CNT:  waddr = cnt_ff;
         spwc_pkg::ASEL_PEND: waddr = pend_idx;
         default:             waddr = req_idx;
      endcase
      case (cmd.raddr_sel)
         spwc_pkg::ASEL_REQ:  raddr = req_idx;
         spwc_pkg::ASEL_CNT:  raddr = cnt_ff;
         spwc_pkg::ASEL_PEND: raddr = pend_idx;
         default:             raddr = req_idx;
      endcase
      case (cmd.page_sel)
         spwc_pkg::PSEL_TAG:  page_mux = tag_ff;
         spwc_pkg::PSEL_REQ:  page_mux = req_page;
         spwc_pkg::PSEL_PEND: page_mux = pend_page;
         default:             page_mux = '0;
      endcase
      wdata = cmd.wdata_pend ? pend_data_ff : req_data;
   end

   spwc_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (PAGE_WORDS)
   ) u_store (
      .clock (clock),
      .we    (cmd.mem_we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      tag_in = cmd.load_tag ? pend_page : tag_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + IDX_BITS'(1);
      end else begin
         cnt_in = cnt_ff;
      end
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.out_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag_ff       <= tag_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pending) begin
         pend_addr_ff <= req_address;
         pend_data_ff <= req_data;
      end
      if (cmd.out_load) begin
         rsp_kind_ff  <= cmd.out_kind;
         rsp_page_ff  <= page_mux;
         rsp_index_ff <= cmd.index_cnt ? cnt_ff : '0;
         rsp_data_ff  <= cmd.data_rd ? rdata : '0;
         rsp_last_ff  <= cmd.out_last;
      end
   end

   assign status.tag_match    = (req_page == tag_ff);
   assign status.counter_last = (cnt_ff == IDX_BITS'(PAGE_WORDS - 1));
   assign status.out_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_page     = rsp_page_ff;
   assign rsp_index    = rsp_index_ff;
   assign rsp_data_res = rsp_data_ff;
   assign rsp_last     = rsp_last_ff;
endmodule

>>> hdl/single_page_writeback_cache_core.sv
// write hit, miss, tick and error results are loaded in the accept state; the last fill
// word moves on through a serve state; read hit and writeback word results go through the
// response state (registered store read), the fetch after the last miss-drain word through
// the second-result state; requests are taken only while the result register is free
// reset: synchronous, clears phase, valid, dirty, tag and result valid; store kept
module single_page_writeback_cache_core #(
   parameter int PAGE_WORDS = spwc_pkg::PAGE_WORDS_DEF,
   parameter int ADDR_BITS  = spwc_pkg::ADDR_BITS_DEF,
   parameter int WORD_BITS  = spwc_pkg::WORD_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   spwc_req_if.sink   req_if,
   spwc_rsp_if.source rsp_if
);
   spwc_pkg::cmd_type    cmd;
   spwc_pkg::status_type status;

   spwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_op    (req_if.op),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   spwc_datapath #(
      .PAGE_WORDS (PAGE_WORDS),
      .ADDR_BITS  (ADDR_BITS),
      .WORD_BITS  (WORD_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_address  (req_if.address),
      .req_data     (req_if.data),
      .cmd          (cmd),
      .status       (status),
      .rsp_ready    (rsp_if.ready),
      .rsp_valid    (rsp_if.valid),
      .rsp_kind     (rsp_if.kind),
      .rsp_page     (rsp_if.page),
      .rsp_index    (rsp_if.index),
      .rsp_data_res (rsp_if.data_res),
      .rsp_last     (rsp_if.last)
   );
endmodule

>>> hdl/spwc_checker.sv
// spwc_checker: port-level assertions for the cache core, attached by bind
// depends on spwc_pkg for result kind codes
module spwc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [spwc_pkg::KIND_BITS-1:0] rsp_kind,
   input logic                           rsp_last
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last))
      else $error("stalled result changed");

   a_only_wb_word_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_kind == spwc_pkg::KIND_WB_WORD)
      else $error("non-final result of wrong kind");

   a_fetch_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_kind == spwc_pkg::KIND_FETCH)
      else $error("fetch needed did not follow final writeback word");

   a_no_accept_mid_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !(req_valid && req_ready))
      else $error("request accepted between paired results");
endmodule

bind single_page_writeback_cache_core spwc_checker u_spwc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_kind  (rsp_if.kind),
   .rsp_last  (rsp_if.last)
);

>>> bench/spwc_result_check.sv
`timescale 1ns / 1ps
// spwc_result_check: tracks the single page write-back cache request by request
// and compares every accepted result with the oldest predicted one
// depends on spwc_pkg; instantiated by tb_single_page_writeback_cache_core
module spwc_result_check
   import spwc_pkg::*;
#(
   parameter int IDX_BITS  = $clog2(PAGE_WORDS_DEF),
   parameter int PAGE_BITS = ADDR_BITS_DEF - IDX_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [OP_BITS-1:0]       req_op,
   input  logic [ADDR_BITS_DEF-1:0] req_address,
   input  logic [WORD_BITS_DEF-1:0] req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [KIND_BITS-1:0]     rsp_kind,
   input  logic [PAGE_BITS-1:0]     rsp_page,
   input  logic [IDX_BITS-1:0]      rsp_index,
   input  logic [WORD_BITS_DEF-1:0] rsp_data_res,
   input  logic                     rsp_last,
   output int                       fail_count,
   output int                       due_count
);

   typedef enum logic [1:0] {CP_IDLE, CP_DRAIN, CP_FILL} cache_phase_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]     kind;
      logic [PAGE_BITS-1:0]     page;
      logic [IDX_BITS-1:0]      index;
      logic [WORD_BITS_DEF-1:0] data_res;
      logic                     last;
   } cache_reply_type;

   cache_reply_type due_replies[$];

   logic [WORD_BITS_DEF-1:0] page_words [PAGE_WORDS_DEF];
   logic                     held_valid;
   logic                     held_dirty;
   logic [PAGE_BITS-1:0]     held_tag;
   cache_phase_type          phase;
   logic [IDX_BITS-1:0]      word_count;
   logic [1:0]               pend_kind;
   logic [ADDR_BITS_DEF-1:0] pend_address;
   logic [WORD_BITS_DEF-1:0] pend_data;

   function automatic void queue_reply(input logic [KIND_BITS-1:0] kind,
                                       input logic [PAGE_BITS-1:0] page,
                                       input logic [IDX_BITS-1:0] index,
                                       input logic [WORD_BITS_DEF-1:0] data_res,
                                       input logic last);
      cache_reply_type r;
      r.kind     = kind;
      r.page     = page;
      r.index    = index;
      r.data_res = data_res;
      r.last     = last;
      due_replies.push_back(r);
   endfunction

   function automatic void serve_hit(input logic is_write, input logic [IDX_BITS-1:0] index,
                                     input logic [WORD_BITS_DEF-1:0] data);
      if (is_write) begin
         page_words[index] = data;
         held_dirty = 1'b1;
         queue_reply(KIND_WRITE_ACK, '0, '0, '0, 1'b1);
      end else begin
         queue_reply(KIND_READ_DATA, '0, '0, page_words[index], 1'b1);
      end
   endfunction

   function automatic void apply_request(input logic [OP_BITS-1:0] op,
                                         input logic [ADDR_BITS_DEF-1:0] address,
                                         input logic [WORD_BITS_DEF-1:0] data);
      logic [PAGE_BITS-1:0] page;
      logic                 fin;
      page = address[ADDR_BITS_DEF-1:IDX_BITS];
      fin  = (word_count == PAGE_WORDS_DEF - 1);
      if ((op == OP_READ || op == OP_WRITE) && phase == CP_IDLE) begin
         if (held_valid && held_tag == page) begin
            serve_hit(op == OP_WRITE, address[IDX_BITS-1:0], data);
         end else begin
            pend_kind    = (op == OP_WRITE) ? PEND_WRITE : PEND_READ;
            pend_address = address;
            pend_data    = data;
            word_count   = '0;
            if (held_valid && held_dirty) begin
               phase = CP_DRAIN;
               queue_reply(KIND_WB_NEEDED, held_tag, '0, '0, 1'b1);
            end else begin
               held_valid = 1'b0;
               held_dirty = 1'b0;
               phase      = CP_FILL;
               queue_reply(KIND_FETCH, page, '0, '0, 1'b1);
            end
         end
      end else if (op == OP_TICK && phase == CP_IDLE) begin
         if (held_valid && held_dirty) begin
            pend_kind  = PEND_FLUSH;
            word_count = '0;
            phase      = CP_DRAIN;
            queue_reply(KIND_WB_NEEDED, held_tag, '0, '0, 1'b1);
         end else begin
            held_valid = 1'b0;
            held_dirty = 1'b0;
         end
      end else if (op == OP_PULL && phase == CP_DRAIN) begin
         queue_reply(KIND_WB_WORD, '0, word_count, page_words[word_count],
                     !fin || pend_kind == PEND_FLUSH);
         if (fin) begin
            word_count = '0;
            held_valid = 1'b0;
            held_dirty = 1'b0;
            if (pend_kind == PEND_FLUSH) begin
               phase = CP_IDLE;
            end else begin
               phase = CP_FILL;
               queue_reply(KIND_FETCH, pend_address[ADDR_BITS_DEF-1:IDX_BITS], '0, '0, 1'b1);
            end
         end else begin
            word_count = word_count + 1'b1;
         end
      end else if (op == OP_FILL && phase == CP_FILL) begin
         page_words[word_count] = data;
         if (fin) begin
            word_count = '0;
            phase      = CP_IDLE;
            held_valid = 1'b1;
            held_dirty = 1'b0;
            held_tag   = pend_address[ADDR_BITS_DEF-1:IDX_BITS];
            serve_hit(pend_kind == PEND_WRITE, pend_address[IDX_BITS-1:0], pend_data);
         end else begin
            word_count = word_count + 1'b1;
         end
      end else begin
         queue_reply(KIND_ERROR, '0, '0, '0, 1'b1);
      end
   endfunction

   function automatic string reply_text(input cache_reply_type r);
      return $sformatf("kind %0d page %0d index %0d data %h last %0d",
                       r.kind, r.page, r.index, r.data_res, r.last);
   endfunction

   function automatic void check_reply();
      cache_reply_type got;
      cache_reply_type want;
      got.kind     = rsp_kind;
      got.page     = rsp_page;
      got.index    = rsp_index;
      got.data_res = rsp_data_res;
      got.last     = rsp_last;
      if (due_replies.size() == 0) begin
         fail_count++;
         $display("%0t: expected no result, got %s", $time, reply_text(got));
      end else begin
         want = due_replies.pop_front();
         if (got !== want) begin
            fail_count++;
            $display("%0t: expected %s, got %s", $time, reply_text(want), reply_text(got));
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held_valid   = 1'b0;
         held_dirty   = 1'b0;
         held_tag     = '0;
         phase        = CP_IDLE;
         word_count   = '0;
         pend_kind    = PEND_READ;
         pend_address = '0;
         pend_data    = '0;
         due_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_reply();
         if (req_valid && req_ready)
            apply_request(req_op, req_address, req_data);
      end
      due_count = due_replies.size();
   end

endmodule

>>> bench/tb_single_page_writeback_cache_core.sv
`timescale 1ns / 1ps
// tb_single_page_writeback_cache_core: drives hit, miss, drain, fill, timeout and
// wrong-phase requests into the cache and gives the verdict
// depends on spwc_pkg, spwc_if, spwc_result_check and the cache core
module tb_single_page_writeback_cache_core;
   import spwc_pkg::*;

   localparam int IDX_BITS     = $clog2(PAGE_WORDS_DEF);
   localparam int PAGE_BITS    = ADDR_BITS_DEF - IDX_BITS;
   localparam int RANDOM_STEPS = 200;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int NOISE_PCT    = 3;

   localparam logic [OP_BITS-1:0] OP_LAST = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;
   int   cycle_count = 0;
   int   fail_count;
   int   due_count;

   logic                 cache_valid = 1'b0;
   logic                 cache_dirty = 1'b0;
   logic [PAGE_BITS-1:0] cache_page  = '0;

   spwc_req_if req_chan ();
   spwc_rsp_if rsp_chan ();

   single_page_writeback_cache_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   spwc_result_check u_result_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .req_op       (req_chan.op),
      .req_address  (req_chan.address),
      .req_data     (req_chan.data),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_kind     (rsp_chan.kind),
      .rsp_page     (rsp_chan.page),
      .rsp_index    (rsp_chan.index),
      .rsp_data_res (rsp_chan.data_res),
      .rsp_last     (rsp_chan.last),
      .fail_count   (fail_count),
      .due_count    (due_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= quiet || ($urandom_range(0, 99) >= 16);
   end

   function automatic logic [WORD_BITS_DEF-1:0] random_word();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[WORD_BITS_DEF-1:0];
   endfunction

   function automatic logic [ADDR_BITS_DEF-1:0] random_address();
      return ADDR_BITS_DEF'($urandom());
   endfunction

   task automatic send_request(input logic [OP_BITS-1:0] op,
                               input logic [ADDR_BITS_DEF-1:0] address,
                               input logic [WORD_BITS_DEF-1:0] data);
      while (!quiet && $urandom_range(0, 99) < 16) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.op      <= op;
      req_chan.address <= address;
      req_chan.data    <= data;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // every op that the current phase rejects
   task automatic phase_errors(input logic [OP_BITS-1:0] good);
      for (int c = OP_READ; c <= OP_LAST; c++)
         if (c != good)
            send_request(OP_BITS'(c), random_address(), random_word());
   endtask

   task automatic stray_request(input logic [OP_BITS-1:0] good);
      logic [OP_BITS-1:0] op;
      do op = OP_BITS'($urandom_range(OP_READ, OP_LAST)); while (op == good);
      send_request(op, random_address(), random_word());
   endtask

   task automatic drain_page(input logic sweep);
      if (sweep)
         phase_errors(OP_PULL);
      for (int i = 0; i < PAGE_WORDS_DEF; i++) begin
         if ($urandom_range(0, 99) < NOISE_PCT)
            stray_request(OP_PULL);
         send_request(OP_PULL, random_address(), random_word());
      end
      cache_valid = 1'b0;
      cache_dirty = 1'b0;
   endtask

   task automatic fill_page(input logic sweep);
      if (sweep)
         phase_errors(OP_FILL);
      for (int i = 0; i < PAGE_WORDS_DEF; i++) begin
         if ($urandom_range(0, 99) < NOISE_PCT)
            stray_request(OP_FILL);
         send_request(OP_FILL, random_address(), random_word());
      end
   endtask

   task automatic access(input logic [OP_BITS-1:0] op,
                         input logic [ADDR_BITS_DEF-1:0] address,
                         input logic [WORD_BITS_DEF-1:0] data,
                         input logic sweep);
      logic [PAGE_BITS-1:0] page;
      page = address[ADDR_BITS_DEF-1:IDX_BITS];
      send_request(op, address, data);
      if (cache_valid && cache_page == page) begin
         if (op == OP_WRITE)
            cache_dirty = 1'b1;
      end else begin
         if (cache_valid && cache_dirty)
            drain_page(sweep);
         fill_page(sweep);
         cache_valid = 1'b1;
         cache_page  = page;
         cache_dirty = (op == OP_WRITE);
      end
   endtask

   task automatic timeout_tick(input logic sweep);
      send_request(OP_TICK, random_address(), random_word());
      if (cache_valid && cache_dirty)
         drain_page(sweep);
      cache_valid = 1'b0;
      cache_dirty = 1'b0;
   endtask

   function automatic logic [OP_BITS-1:0] read_or_write();
      return $urandom_range(0, 1) ? OP_WRITE : OP_READ;
   endfunction

   initial begin
      int pick;
      req_chan.valid   = 1'b0;
      req_chan.op      = OP_READ;
      req_chan.address = '0;
      req_chan.data    = '0;
      rsp_chan.ready   = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // wrong ops in idle, tick with nothing cached
      for (int c = OP_PULL; c <= OP_LAST; c++)
         send_request(OP_BITS'(c), random_address(), random_word());
      send_request(OP_TICK, '0, '0);
      // empty miss with every wrong op during fill
      access(OP_READ, '1, '0, 1'b1);
      access(OP_WRITE, {{PAGE_BITS{1'b1}}, {IDX_BITS{1'b0}}}, '1, 1'b0);
      access(OP_READ, {{PAGE_BITS{1'b1}}, {IDX_BITS{1'b0}}}, '0, 1'b0);
      access(OP_WRITE, '1, '0, 1'b0);
      // dirty flush with every wrong op during drain
      timeout_tick(1'b1);
      timeout_tick(1'b0);
      access(OP_WRITE, '0, '1, 1'b0);

      // hits and stray ops on the held page
      for (int n = 0; n < RANDOM_STEPS; n++) begin
         quiet = (n >= 50 && n < 150);
         pick  = $urandom_range(0, 99);
         if (pick < 12) begin
            send_request(OP_BITS'($urandom_range(OP_PULL, OP_LAST)), random_address(),
                         random_word());
         end else begin
            access(read_or_write(), {cache_page, IDX_BITS'($urandom())}, random_word(), 1'b0);
         end
      end
      quiet = 1'b0;

      // dirty miss: drain, fetch, fill
      access(OP_READ, {PAGE_BITS'(5), IDX_BITS'($urandom())}, '0, 1'b1);
      // clean page dropped by a tick
      timeout_tick(1'b0);
      req_chan.valid <= 1'b0;

      while (due_count != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0 && due_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
